/* rtl/ablm_pkg.sv */
// Shared types and constants for the audio block level meter.
`timescale 1ns / 1ps

package ablm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int RMS_W      = 16;
    localparam int VOL_W      = 7;
    localparam int VOL_PROD_W = 22;
    localparam int VOL_SHIFT  = 15;
    localparam int RAD_W      = 32;
    localparam int ROOT_STEPS = 16;

    localparam logic [VOL_PROD_W-1:0] VOL_SCALE = VOL_PROD_W'(100);

    localparam logic signed [SAMPLE_W-1:0] MIN_INIT = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] MAX_INIT = 16'sh8000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_SQ,
        ST_DIV_SUM,
        ST_SQRT,
        ST_DONE
    } state_t;

endpackage

/* rtl/audio_block_level_meter.sv */
// Block level meter: running sums per block, then divide and root on a shared subtractor.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------------------------
//   in      | in_valid, in_ready  | sample, block_end
//   out     | out_valid, out_ready| rms_level, volume_pct, mean_value, min_sample,
//           |                     | max_sample
//
// A sample that does not end its block is accumulated, and the meter stays ready for the next one.
// A block-ending sample holds in_ready low through two restoring divides, one quotient bit
// per cycle, and 16 root steps, all on one subtractor, and then until the finished result
// is moved to the output register.
// A waiting result does not stop accumulation of the next block; a finished result
// only stalls while the previous one is still untaken.
// Reset clears the accumulators and leaves no result pending.
`timescale 1ns / 1ps

module audio_block_level_meter #(
    parameter int MAX_BLOCK_SAMPLES = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [ablm_pkg::SAMPLE_W-1:0] sample,
    input  logic                                block_end,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ablm_pkg::RMS_W-1:0]          rms_level,
    output logic [ablm_pkg::VOL_W-1:0]          volume_pct,
    output logic signed [ablm_pkg::SAMPLE_W-1:0] mean_value,
    output logic signed [ablm_pkg::SAMPLE_W-1:0] min_sample,
    output logic signed [ablm_pkg::SAMPLE_W-1:0] max_sample
);

    import ablm_pkg::*;

    localparam int CNT_W  = $clog2(MAX_BLOCK_SAMPLES + 1);
    localparam int SUM_W  = SAMPLE_W + CNT_W;
    localparam int SQ_W   = 31 + CNT_W;
    localparam int DVD_W  = SQ_W;
    localparam int UNIT_W = (CNT_W + 1 > 20) ? CNT_W + 1 : 20;
    localparam int STEP_W = $clog2(DVD_W);

    state_t state_reg, state_next;

    logic signed [SUM_W-1:0]    acc_sum_reg;
    logic [SQ_W-1:0]            acc_sq_reg;
    logic [CNT_W-1:0]           acc_cnt_reg;
    logic signed [SAMPLE_W-1:0] acc_min_reg;
    logic signed [SAMPLE_W-1:0] acc_max_reg;

    logic [DVD_W-1:0]           dvd_reg;
    logic [UNIT_W-1:0]          rem_reg;
    logic [CNT_W-1:0]           divisor_reg;
    logic                       sum_neg_reg;
    logic [SUM_W-2:0]           sum_mag_reg;
    logic [RAD_W-1:0]           rad_reg;
    logic [RMS_W-1:0]           root_reg;
    logic signed [SAMPLE_W-1:0] mean_reg;
    logic signed [SAMPLE_W-1:0] min_hold_reg;
    logic signed [SAMPLE_W-1:0] max_hold_reg;
    logic [STEP_W-1:0]          step_reg;

    logic                       out_valid_reg;
    logic [RMS_W-1:0]           rms_reg;
    logic [VOL_W-1:0]           vol_reg;
    logic signed [SAMPLE_W-1:0] mean_out_reg;
    logic signed [SAMPLE_W-1:0] min_out_reg;
    logic signed [SAMPLE_W-1:0] max_out_reg;

    logic                       in_fire;
    logic                       out_free;
    logic                       ending;
    logic signed [31:0]         sq_prod;
    logic signed [SUM_W-1:0]    sum_total;
    logic signed [SUM_W-1:0]    sum_abs;
    logic [SQ_W-1:0]            sq_total;
    logic [CNT_W-1:0]           cnt_total;
    logic signed [SAMPLE_W-1:0] min_total;
    logic signed [SAMPLE_W-1:0] max_total;

    logic [UNIT_W-1:0]          div_shift;
    logic [UNIT_W-1:0]          root_shift;
    logic [UNIT_W-1:0]          unit_a;
    logic [UNIT_W-1:0]          unit_b;
    logic [UNIT_W:0]            unit_diff;
    logic                       unit_ge;
    logic [DVD_W-1:0]           dvd_next;
    logic [UNIT_W-1:0]          rem_next;
    logic [RMS_W-1:0]           root_next;
    logic [SAMPLE_W-1:0]        quot_low;
    logic                       last_div;
    logic                       last_root;
    logic [VOL_PROD_W-1:0]      vol_prod;

    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign sq_prod   = sample * sample;
    assign sum_total = acc_sum_reg + SUM_W'(sample);
    assign sq_total  = acc_sq_reg + SQ_W'($unsigned(sq_prod));
    assign cnt_total = acc_cnt_reg + CNT_W'(1);
    assign min_total = (sample < acc_min_reg) ? sample : acc_min_reg;
    assign max_total = (sample > acc_max_reg) ? sample : acc_max_reg;
    assign ending    = block_end || (cnt_total == CNT_W'(MAX_BLOCK_SAMPLES));
    assign sum_abs   = sum_total[SUM_W-1] ? -sum_total : sum_total;

    assign div_shift  = {rem_reg[UNIT_W-2:0], dvd_reg[DVD_W-1]};
    assign root_shift = {rem_reg[UNIT_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign unit_diff  = {1'b0, unit_a} - {1'b0, unit_b};
    assign unit_ge    = !unit_diff[UNIT_W];
    assign rem_next   = unit_ge ? unit_diff[UNIT_W-1:0] : unit_a;
    assign dvd_next   = {dvd_reg[DVD_W-2:0], unit_ge};
    assign root_next  = {root_reg[RMS_W-2:0], unit_ge};
    assign quot_low   = dvd_next[SAMPLE_W-1:0];
    assign last_div   = (step_reg == STEP_W'(DVD_W - 1));
    assign last_root  = (step_reg == STEP_W'(ROOT_STEPS - 1));
    assign vol_prod   = VOL_PROD_W'(root_reg) * VOL_SCALE;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && ending)
                begin
                    state_next = ST_DIV_SQ;
                end
            end
            ST_DIV_SQ:
            begin
                if (last_div)
                begin
                    state_next = ST_DIV_SUM;
                end
            end
            ST_DIV_SUM:
            begin
                if (last_div)
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (last_root)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        unit_a   = '0;
        unit_b   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_DIV_SQ, ST_DIV_SUM:
            begin
                unit_a = div_shift;
                unit_b = UNIT_W'(divisor_reg);
            end
            ST_SQRT:
            begin
                unit_a = root_shift;
                unit_b = UNIT_W'({root_reg, 2'b01});
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            acc_sum_reg   <= '0;
            acc_sq_reg    <= '0;
            acc_cnt_reg   <= '0;
            acc_min_reg   <= MIN_INIT;
            acc_max_reg   <= MAX_INIT;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg != state_next)
            begin
                step_reg <= '0;
            end
            else if (state_reg != ST_IDLE && state_reg != ST_DONE)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end

            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (in_fire)
            begin
                if (ending)
                begin
                    acc_sum_reg <= '0;
                    acc_sq_reg  <= '0;
                    acc_cnt_reg <= '0;
                    acc_min_reg <= MIN_INIT;
                    acc_max_reg <= MAX_INIT;
                end
                else
                begin
                    acc_sum_reg <= sum_total;
                    acc_sq_reg  <= sq_total;
                    acc_cnt_reg <= cnt_total;
                    acc_min_reg <= min_total;
                    acc_max_reg <= max_total;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && ending)
                begin
                    dvd_reg      <= DVD_W'(sq_total);
                    rem_reg      <= '0;
                    divisor_reg  <= cnt_total;
                    sum_neg_reg  <= sum_total[SUM_W-1];
                    sum_mag_reg  <= sum_abs[SUM_W-2:0];
                    min_hold_reg <= min_total;
                    max_hold_reg <= max_total;
                end
            end
            ST_DIV_SQ:
            begin
                if (last_div)
                begin
                    rad_reg <= dvd_next[RAD_W-1:0];
                    dvd_reg <= DVD_W'(sum_mag_reg);
                    rem_reg <= '0;
                end
                else
                begin
                    dvd_reg <= dvd_next;
                    rem_reg <= rem_next;
                end
            end
            ST_DIV_SUM:
            begin
                if (last_div)
                begin
                    mean_reg <= sum_neg_reg ? -$signed(quot_low) : $signed(quot_low);
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
                else
                begin
                    dvd_reg <= dvd_next;
                    rem_reg <= rem_next;
                end
            end
            ST_SQRT:
            begin
                rem_reg  <= rem_next;
                root_reg <= root_next;
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rms_reg      <= root_reg;
                    vol_reg      <= vol_prod[VOL_SHIFT +: VOL_W];
                    mean_out_reg <= mean_reg;
                    min_out_reg  <= min_hold_reg;
                    max_out_reg  <= max_hold_reg;
                end
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign rms_level  = rms_reg;
    assign volume_pct = vol_reg;
    assign mean_value = mean_out_reg;
    assign min_sample = min_out_reg;
    assign max_sample = max_out_reg;

endmodule

/* rtl/ablm_checker.sv */
// Port-level checks for the audio block level meter, bound to the top level.
`timescale 1ns / 1ps

module ablm_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                block_end,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [ablm_pkg::RMS_W-1:0]          rms_level,
    input logic [ablm_pkg::VOL_W-1:0]          volume_pct,
    input logic signed [ablm_pkg::SAMPLE_W-1:0] mean_value,
    input logic signed [ablm_pkg::SAMPLE_W-1:0] min_sample,
    input logic signed [ablm_pkg::SAMPLE_W-1:0] max_sample
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rms_level) && $stable(mean_value))
        else $error("pending result word changed before it was taken");

    a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && block_end |=> !in_ready)
        else $error("input ready right after a block-ending word");

    a_vol_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> volume_pct <= 7'd100)
        else $error("volume above 100 percent");

    a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> min_sample <= mean_value && mean_value <= max_sample)
        else $error("mean outside the block's min and max");

endmodule

bind audio_block_level_meter ablm_checker u_ablm_checker (.*);
